/* hdl/dsfd_pkg.sv */
// package: item types, parser state codes and byte constants for the deframer
`timescale 1ns / 1ps

package dsfd_pkg;

  localparam int TEXT_DEPTH       = 128;
  localparam int MAX_FRAME_LENGTH = 127;
  localparam int TABLE_DEPTH      = 256;
  localparam int LEN_W            = 7;

  localparam logic [7:0] SYNC_FIRST  = 8'hBC;
  localparam logic [7:0] SYNC_SECOND = 8'hCD;
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;

  localparam logic [1:0] FDONE_NONE  = 2'd0;
  localparam logic [1:0] FDONE_WRITE = 2'd1;
  localparam logic [1:0] FDONE_READ  = 2'd2;

  localparam logic [LEN_W-1:0] LEN_UNKNOWN = 7'd0;
  localparam logic [LEN_W-1:0] LEN_READ    = 7'd1;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_LOAD = 2'd1,
    OP_ACK  = 2'd2,
    OP_RSVD = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    HDR_HUNT   = 2'd0,
    HDR_GOT_BC = 2'd1,
    HDR_BODY   = 2'd2
  } hdr_state_t;

  typedef enum logic [1:0] {
    TXT_IDLE    = 2'd0,
    TXT_BODY    = 2'd1,
    TXT_WAIT_LF = 2'd2
  } txt_state_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [7:0]       rx_byte;
    logic [7:0]       table_command;
    logic [LEN_W-1:0] table_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             frame_store_valid;
    logic [6:0]       frame_index;
    logic [1:0]       frame_done;
    logic [LEN_W-1:0] frame_length;
    logic             text_store_valid;
    logic [6:0]       text_index;
    logic             text_done;
    logic [7:0]       text_length;
  } out_item_t;

endpackage

/* hdl/dual_serial_frame_deframer_unit.sv */
// top level: binary frame and text packet parsers over one received byte stream
// a request goes through the input register and then the result register
// throughput: one request per cycle when not stalled; the length table read is
// issued at accept; its registered data meets the request in the input register
// reset: synchronous active-low rst_n clears both parsers, pending flag and the
// per-entry table valid bits, so every command is unknown at once (no sweep)
`timescale 1ns / 1ps

module dual_serial_frame_deframer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dsfd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dsfd_pkg::out_item_t out_data
);
  import dsfd_pkg::*;

  localparam int TBL_AW = $clog2(TABLE_DEPTH);

  // handshake
  logic      in_acc;
  logic      out_adv;
  logic      fire;
  logic      s1_vld_r;
  in_item_t  s1_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t res;

  assign out_adv  = !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;
  assign fire     = s1_vld_r && out_adv;

  // length table
  logic                   tbl_we;
  logic [LEN_W-1:0]       tbl_wdata;
  logic [LEN_W-1:0]       tbl_rdata;
  logic [TABLE_DEPTH-1:0] tbl_vld_r;
  logic                   lk_vld_r;
  logic [LEN_W-1:0]       lookup;

  assign tbl_we    = in_acc && (in_data.operation == OP_LOAD);
  assign tbl_wdata = ({1'b0, in_data.table_length} > 8'(MAX_FRAME_LENGTH)) ?
                     LEN_W'(MAX_FRAME_LENGTH) : in_data.table_length;

  dsfd_ram #(
    .WIDTH(LEN_W),
    .DEPTH(TABLE_DEPTH)
  ) u_len_ram (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(in_data.table_command[TBL_AW-1:0]),
    .wdata(tbl_wdata),
    .re   (in_acc),
    .raddr(in_data.rx_byte[TBL_AW-1:0]),
    .rdata(tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      lk_vld_r  <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_r[in_data.table_command[TBL_AW-1:0]] <= 1'b1;
      end
      if (in_acc) begin
        lk_vld_r <= tbl_vld_r[in_data.rx_byte[TBL_AW-1:0]];
      end
    end
  end

  assign lookup = lk_vld_r ? tbl_rdata : LEN_UNKNOWN;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
  end

  // parser state
  hdr_state_t       hdr_r, hdr_nxt;
  logic [6:0]       fcnt_r, fcnt_nxt;
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  txt_state_t       txt_r, txt_nxt;
  logic [7:0]       tpos_r, tpos_nxt;
  logic             tpend_r, tpend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r     <= HDR_HUNT;
      fcnt_r    <= '0;
      cur_len_r <= '0;
      txt_r     <= TXT_IDLE;
      tpos_r    <= '0;
      tpend_r   <= 1'b0;
    end else if (fire) begin
      hdr_r     <= hdr_nxt;
      fcnt_r    <= fcnt_nxt;
      cur_len_r <= cur_len_nxt;
      txt_r     <= txt_nxt;
      tpos_r    <= tpos_nxt;
      tpend_r   <= tpend_nxt;
    end
  end

  logic [7:0]       b;
  logic             is_byte;
  logic [LEN_W-1:0] flen;
  logic [6:0]       fcnt_inc;

  assign b        = s1_item_r.rx_byte;
  assign is_byte  = (s1_item_r.operation == OP_BYTE);
  assign flen     = (fcnt_r == '0) ? lookup : cur_len_r;
  assign fcnt_inc = fcnt_r + 7'd1;

  always_comb begin
    hdr_nxt     = hdr_r;
    fcnt_nxt    = fcnt_r;
    cur_len_nxt = cur_len_r;
    txt_nxt     = txt_r;
    tpos_nxt    = tpos_r;
    tpend_nxt   = tpend_r;
    res         = '0;

    if (s1_item_r.operation == OP_ACK) begin
      tpend_nxt = 1'b0;
    end

    if (is_byte) begin
      // binary parser
      case (hdr_r)
        HDR_HUNT: begin
          if (b == SYNC_FIRST) begin
            hdr_nxt = HDR_GOT_BC;
          end
        end
        HDR_GOT_BC: begin
          if (b == SYNC_SECOND) begin
            hdr_nxt     = HDR_BODY;
            fcnt_nxt    = '0;
            cur_len_nxt = '0;
          end else begin
            hdr_nxt = HDR_HUNT;
          end
        end
        HDR_BODY: begin
          if (fcnt_r == '0) begin
            cur_len_nxt = lookup;
          end
          if (flen == LEN_UNKNOWN) begin
            // unknown command dropped, next byte is taken as command
          end else if (flen == LEN_READ) begin
            res.frame_store_valid = 1'b1;
            res.frame_done        = FDONE_READ;
            res.frame_length      = LEN_READ;
            fcnt_nxt              = 7'd1;
            hdr_nxt               = HDR_HUNT;
          end else begin
            res.frame_store_valid = 1'b1;
            res.frame_index       = fcnt_r;
            fcnt_nxt              = fcnt_inc;
            if (fcnt_inc >= flen || fcnt_inc == '0) begin
              res.frame_done   = FDONE_WRITE;
              res.frame_length = flen;
              hdr_nxt          = HDR_HUNT;
            end
          end
        end
        default: begin
          hdr_nxt = HDR_HUNT;
        end
      endcase

      // text parser
      case (txt_r)
        TXT_IDLE: begin
          if (b == CH_AT && !tpend_r) begin
            txt_nxt  = TXT_BODY;
            tpos_nxt = '0;
          end
        end
        TXT_BODY: begin
          if (b == CH_CR) begin
            txt_nxt = TXT_WAIT_LF;
          end else if (tpos_r < 8'(TEXT_DEPTH)) begin
            res.text_store_valid = 1'b1;
            res.text_index       = tpos_r[6:0];
            tpos_nxt             = tpos_r + 8'd1;
          end
        end
        TXT_WAIT_LF: begin
          if (b == CH_LF) begin
            txt_nxt         = TXT_IDLE;
            tpend_nxt       = 1'b1;
            res.text_done   = 1'b1;
            res.text_length = tpos_r;
          end
        end
        default: begin
          txt_nxt = TXT_IDLE;
        end
      endcase
    end

    res.data_byte = (res.frame_store_valid || res.text_store_valid) ? b : 8'd0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // checks
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_vld_r && out_stall))
    else $error("input stalled without a blocked result");

  a_done_stores: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_item_r.frame_done != FDONE_NONE) |-> out_item_r.frame_store_valid)
    else $error("frame completed without storing a byte");

  a_read_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_item_r.frame_done == FDONE_READ) |->
      (out_item_r.frame_length == LEN_READ && out_item_r.frame_index == '0))
    else $error("read request with bad length or index");

  a_text_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_item_r.text_done && out_item_r.text_store_valid))
    else $error("text byte stored on packet completion");

endmodule

/* hdl/dsfd_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module dsfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* verif/tb_top.sv */
// testbench: drives byte, table load and acknowledge requests into the deframer and checks results
`timescale 1ns / 1ps

module tb_top;
  import dsfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  dual_serial_frame_deframer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // predicted parser state
  hdr_state_t       hdr_state;
  logic [6:0]       frame_cnt;
  logic [LEN_W-1:0] frame_len;
  logic [LEN_W-1:0] len_table [TABLE_DEPTH];
  txt_state_t       txt_state;
  logic [7:0]       txt_pos;
  logic             txt_pending;

  out_item_t   expected_results [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned sent_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // what the stimulus side has loaded, used to shape well-formed frames
  logic [LEN_W-1:0] loaded_len [TABLE_DEPTH];
  logic [7:0]       known_cmds [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void reset_parsers();
    hdr_state   = HDR_HUNT;
    frame_cnt   = '0;
    frame_len   = '0;
    txt_state   = TXT_IDLE;
    txt_pos     = '0;
    txt_pending = 1'b0;
    foreach (len_table[i]) begin
      len_table[i]  = LEN_UNKNOWN;
      loaded_len[i] = LEN_UNKNOWN;
    end
  endfunction

  function automatic out_item_t deframe_byte(in_item_t req);
    out_item_t  res;
    logic [7:0] b;
    int         len;
    res = '0;
    b   = req.rx_byte;
    case (req.operation)
      OP_LOAD: begin
        len = int'(req.table_length);
        if (len > MAX_FRAME_LENGTH) len = MAX_FRAME_LENGTH;
        len_table[req.table_command] = len[LEN_W-1:0];
      end
      OP_ACK: txt_pending = 1'b0;
      OP_BYTE: begin
        case (hdr_state)
          HDR_HUNT: begin
            if (b == SYNC_FIRST) hdr_state = HDR_GOT_BC;
          end
          HDR_GOT_BC: begin
            if (b == SYNC_SECOND) begin
              hdr_state = HDR_BODY;
              frame_cnt = '0;
              frame_len = '0;
            end else begin
              hdr_state = HDR_HUNT;
            end
          end
          default: begin
            if (frame_cnt == 0) frame_len = len_table[b];
            if (frame_len == LEN_READ) begin
              res.frame_store_valid = 1'b1;
              res.frame_done        = FDONE_READ;
              res.frame_length      = LEN_READ;
              frame_cnt             = 7'd1;
              hdr_state             = HDR_HUNT;
            end else if (frame_len != LEN_UNKNOWN) begin
              res.frame_store_valid = 1'b1;
              res.frame_index       = frame_cnt;
              frame_cnt             = frame_cnt + 7'd1;
              // a wrapped count also closes the frame
              if (frame_cnt >= frame_len || frame_cnt == 0) begin
                res.frame_done   = FDONE_WRITE;
                res.frame_length = frame_len;
                hdr_state        = HDR_HUNT;
              end
            end
          end
        endcase
        case (txt_state)
          TXT_IDLE: begin
            if (b == CH_AT && !txt_pending) begin
              txt_state = TXT_BODY;
              txt_pos   = '0;
            end
          end
          TXT_BODY: begin
            if (b == CH_CR) begin
              txt_state = TXT_WAIT_LF;
            end else if (txt_pos < TEXT_DEPTH) begin
              res.text_store_valid = 1'b1;
              res.text_index       = txt_pos[6:0];
              txt_pos              = txt_pos + 8'd1;
            end
          end
          default: begin
            if (b == CH_LF) begin
              txt_state       = TXT_IDLE;
              txt_pending     = 1'b1;
              res.text_done   = 1'b1;
              res.text_length = txt_pos;
            end
          end
        endcase
        if (res.frame_store_valid || res.text_store_valid) res.data_byte = b;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
    end
  endfunction

  function automatic void check_result(out_item_t exp, out_item_t act);
    check_field("data_byte", exp.data_byte, act.data_byte);
    check_field("frame_store_valid", exp.frame_store_valid, act.frame_store_valid);
    check_field("frame_index", exp.frame_index, act.frame_index);
    check_field("frame_done", exp.frame_done, act.frame_done);
    check_field("frame_length", exp.frame_length, act.frame_length);
    check_field("text_store_valid", exp.text_store_valid, act.text_store_valid);
    check_field("text_index", exp.text_index, act.text_index);
    check_field("text_done", exp.text_done, act.text_done);
    check_field("text_length", exp.text_length, act.text_length);
  endfunction

  // results are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none actual %p", $time, out_data);
        end else begin
          check_result(expected_results.pop_front(), out_data);
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(deframe_byte(in_data));
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: watchdog, nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  // in_valid stays high between back-to-back requests
  task automatic send_req(input in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t req;
    req.operation     = OP_BYTE;
    req.rx_byte       = b;
    req.table_command = 8'($urandom);
    req.table_length  = LEN_W'($urandom);
    send_req(req);
  endtask

  task automatic send_load(input logic [7:0] cmd, input logic [LEN_W-1:0] len);
    in_item_t req;
    req.operation     = OP_LOAD;
    req.rx_byte       = 8'($urandom);
    req.table_command = cmd;
    req.table_length  = len;
    loaded_len[cmd]   = len;
    if (len != LEN_UNKNOWN) known_cmds.push_back(cmd);
    send_req(req);
  endtask

  task automatic send_ack();
    in_item_t req;
    req               = $bits(in_item_t)'($urandom);
    req.operation     = OP_ACK;
    send_req(req);
  endtask

  // any request at all, the unused operation code included
  task automatic send_any();
    in_item_t req;
    req = $bits(in_item_t)'($urandom);
    send_req(req);
  endtask

  function automatic logic [7:0] pick_command();
    logic [7:0] c;
    c = known_cmds[$urandom_range(known_cmds.size() - 1)];
    // keep long frames rare
    for (int k = 0; k < 4 && loaded_len[c] > 16; k++)
      c = known_cmds[$urandom_range(known_cmds.size() - 1)];
    return c;
  endfunction

  task automatic send_frame(input logic [7:0] cmd, input bit unknown_first);
    logic [7:0] c;
    int         payload;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    if (unknown_first) begin
      do c = 8'($urandom); while (loaded_len[c] != LEN_UNKNOWN);
      send_byte(c);
    end
    send_byte(cmd);
    payload = (loaded_len[cmd] > 1) ? loaded_len[cmd] - 1 : 0;
    repeat (payload) send_byte(8'($urandom));
  endtask

  task automatic send_text(input int unsigned body_len, input bit junk_after_cr);
    logic [7:0] b;
    send_byte(CH_AT);
    repeat (body_len) begin
      do b = 8'($urandom); while (b == CH_CR);
      send_byte(b);
    end
    send_byte(CH_CR);
    if (junk_after_cr) begin
      do b = 8'($urandom); while (b == CH_LF);
      send_byte(b);
    end
    send_byte(CH_LF);
  endtask

  task automatic test_frames();
    send_load(8'h00, LEN_READ);
    send_load(8'hFF, 7'd127);
    send_load(8'h21, 7'd3);
    // repeated first header byte falls back to hunting
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    // unknown command skipped, read request follows
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(SYNC_FIRST);
    send_byte(8'h12);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h21);
    send_byte(8'h77);
    send_byte(8'h88);
  endtask

  task automatic test_text();
    send_byte(CH_AT);
    send_byte(8'h41);
    send_byte(CH_CR);
    send_byte(8'h33);
    send_byte(CH_LF);
    // start ignored while the packet is pending
    send_byte(CH_AT);
    send_ack();
    send_text(0, 1'b0);
    send_ack();
  endtask

  task automatic test_unused_op();
    in_item_t req;
    req           = $bits(in_item_t)'($urandom);
    req.operation = OP_RSVD;
    send_req(req);
  endtask

  task automatic test_text_overflow();
    // close whatever text is open, then a body that fills or passes capacity
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_ack();
    send_text(TEXT_DEPTH + $urandom_range(6), 1'b0);
    send_ack();
  endtask

  task automatic test_random_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  c;
    stop_at = sent_count + n;
    while (sent_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_frame(pick_command(), $urandom_range(5) == 0);
      end else if (pick < 60) begin
        send_text($urandom_range(12), $urandom_range(3) == 0);
        if ($urandom_range(9) < 7) send_ack();
      end else if (pick < 70) begin
        c = 8'($urandom);
        case ($urandom_range(15))
          0:       send_load(c, LEN_W'($urandom_range(127)));
          1, 2:    send_load(c, LEN_READ);
          3:       send_load(c, LEN_UNKNOWN);
          default: send_load(c, LEN_W'($urandom_range(10, 2)));
        endcase
      end else if (pick < 78) begin
        send_ack();
      end else if (pick < 84) begin
        send_any();
      end else begin
        send_byte(($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    reset_parsers();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 10;
    recv_stall_pct = 54;
    test_frames();
    test_text();
    test_unused_op();
    test_random_traffic(130);
    test_text_overflow();

    send_idle_pct  = 54;
    recv_stall_pct = 10;
    test_random_traffic(130);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(130);
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
